FILE: rtl/relative_yaw_turn_controller_assert.svh
// Assertion shorthands for the relative yaw turn controller.
// Each checks on the rising edge of clk and is quiet while arst_n is low.
`ifndef RELATIVE_YAW_TURN_CONTROLLER_ASSERT_SVH
`define RELATIVE_YAW_TURN_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define RYT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("turn controller check failed");

// Next-cycle implication
`define RYT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("turn controller check failed");

`endif

FILE: rtl/ryt_pkg.sv
package ryt_pkg;

	// Request kinds on the input tuser
	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_CANCEL = 2'd2;

	// End codes
	localparam logic [1:0] END_NONE      = 2'd0;
	localparam logic [1:0] END_COMPLETED = 2'd1;
	localparam logic [1:0] END_TIMEOUT   = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_TARGET   = 3'd0;
	localparam logic [2:0] REG_TIMEOUT  = 3'd1;
	localparam logic [2:0] REG_GAIN     = 3'd2;
	localparam logic [2:0] REG_MAX_RATE = 3'd3;
	localparam logic [2:0] REG_TOL      = 3'd4;
	localparam logic [2:0] REG_RATE_LIM = 3'd5;
	localparam logic [2:0] REG_SETTLE   = 3'd6;

	// Register reset values
	localparam logic [15:0] GAIN_RST     = 16'd2287;
	localparam logic [17:0] MAX_RATE_RST = 18'd98304;
	localparam logic [14:0] TOL_RST      = 15'd512;
	localparam logic [15:0] RATE_LIM_RST = 16'd1280;
	localparam logic [15:0] SETTLE_RST   = 16'd100;

	// Arithmetic constants
	localparam logic [8:0]  DT_FALLBACK = 9'd20;
	localparam logic [31:0] DT_MAX      = 32'd500;
	localparam logic signed [26:0] K_MILLI = 27'sd1000;
	localparam logic signed [26:0] K_DIV   = 27'sd125;
	// floor(2^32 / 125) + 1: exact quotient by 125 for dividends below 2^25
	localparam logic signed [26:0] K_RECIP = 27'sd34359739;
	localparam logic [54:0] K_HALF = 55'd128000;
	localparam logic signed [48:0] ERR_LIM = 49'sd137438953472;
	localparam logic [37:0] EMAG_LIM = 38'h20_0000_0000;
	localparam logic signed [47:0] TURN_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] TURN_MIN = 48'sh8000_0000_0000;

	// Program steps
	typedef logic [3:0] step_t;
	localparam step_t STEP_DECODE  = 4'd0;
	localparam step_t STEP_RATE    = 4'd1;
	localparam step_t STEP_ACCUM   = 4'd2;
	localparam step_t STEP_ERROR   = 4'd3;
	localparam step_t STEP_SETTLE  = 4'd4;
	localparam step_t STEP_PROD_LO = 4'd5;
	localparam step_t STEP_PROD_HI = 4'd6;
	localparam step_t STEP_ROUND   = 4'd7;
	localparam step_t STEP_SCALE   = 4'd8;
	localparam step_t STEP_COMMAND = 4'd9;
	localparam step_t STEP_EMIT    = 4'd10;

	typedef enum logic [3:0] {
		OP_DECODE,
		OP_MUL_RATE,
		OP_ACCUM,
		OP_ERROR,
		OP_SETTLE,
		OP_PROD_LO,
		OP_PROD_HI,
		OP_ROUND,
		OP_SCALE,
		OP_COMMAND,
		OP_EMIT
	} op_t;

	typedef enum logic {
		JMP_NEXT,
		JMP_IF_END
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
	} cw_t;

	// Control store: one word per step
	function automatic cw_t ucode(input step_t step);
		cw_t cw;
		cw = '{op: OP_EMIT, jmp: JMP_NEXT, target: STEP_EMIT};
		case (step)
			STEP_DECODE:  cw = '{op: OP_DECODE,   jmp: JMP_IF_END, target: STEP_EMIT};
			STEP_RATE:    cw = '{op: OP_MUL_RATE, jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_ACCUM:   cw = '{op: OP_ACCUM,    jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_ERROR:   cw = '{op: OP_ERROR,    jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_SETTLE:  cw = '{op: OP_SETTLE,   jmp: JMP_IF_END, target: STEP_EMIT};
			STEP_PROD_LO: cw = '{op: OP_PROD_LO,  jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_PROD_HI: cw = '{op: OP_PROD_HI,  jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_ROUND:   cw = '{op: OP_ROUND,    jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_SCALE:   cw = '{op: OP_SCALE,    jmp: JMP_NEXT,   target: STEP_EMIT};
			STEP_COMMAND: cw = '{op: OP_COMMAND,  jmp: JMP_NEXT,   target: STEP_EMIT};
			default:      cw = '{op: OP_EMIT,     jmp: JMP_NEXT,   target: STEP_EMIT};
		endcase
		return cw;
	endfunction

endpackage

FILE: rtl/relative_yaw_turn_controller.sv
// An update that gives a command runs every step of the eleven-step control program, which
// shares one 27x27 multiplier; one that completes the turn jumps to emit after the settle step,
// every other item jumps to emit after decode. A stalled output holds the program at emit, and
// no new item is accepted until the current one has loaded its output word.
// Reset (arst_n low, asynchronous): turn state and control cleared, registers at defaults.
`include "relative_yaw_turn_controller_assert.svh"

module relative_yaw_turn_controller import ryt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // now_ms[31:0], yaw_rate[51:32], cancel_reason[53:52]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // turn_rate[18:0], command_valid[19],
	                                   // start_accepted[20], turn_active[21], end_code[23:22]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	// Configuration registers
	logic signed [20:0] cfg_target_q;
	logic [31:0]        cfg_timeout_q;
	logic [15:0]        cfg_gain_q;
	logic [17:0]        cfg_max_rate_q;
	logic [14:0]        cfg_tol_q;
	logic [15:0]        cfg_rate_lim_q;
	logic [15:0]        cfg_settle_q;

	// Sequencer and turn state
	logic               busy_q;
	step_t              pc_q;
	logic               running_q;
	logic               settling_q;
	logic signed [47:0] turned_q;
	logic [31:0]        last_q;
	logic [31:0]        start_q;
	logic [31:0]        sst_q;
	logic [1:0]         finish_q;
	logic signed [20:0] lat_target_q;
	logic [31:0]        lat_timeout_q;
	logic signed [18:0] cmd_q;
	logic               valid_q;
	logic               accepted_q;
	logic               out_valid_q;
	logic [23:0]        out_data_q;

	// Datapath scratch
	logic [1:0]         req_q;
	logic [31:0]        now_q;
	logic signed [19:0] rate_q;
	logic [1:0]         reason_q;
	logic [8:0]         dt_q;
	logic signed [53:0] prod_q;
	logic signed [48:0] err_q;
	logic [37:0]        emag_q;
	logic               esign_q;
	logic [54:0]        pm_q;
	logic               big_q;

	cw_t                cw;
	logic               in_fire;
	logic               out_free;
	logic               emit_go;
	logic               end_now;
	logic [31:0]        elapsed;
	logic               timed_out;
	logic [31:0]        dt_raw;
	logic [8:0]         dt_next;
	logic               start_ok;
	logic signed [48:0] sum49;
	logic signed [47:0] turned_sat;
	logic signed [48:0] err_next;
	logic signed [48:0] err_neg;
	logic signed [48:0] tol_pos;
	logic [19:0]        rate_abs;
	logic               settled;
	logic               settle_hit;
	logic [37:0]        emag_next;
	logic [43:0]        quo_pre;
	logic [17:0]        mag;
	logic [18:0]        mag19;
	logic signed [18:0] cmd_next;
	logic signed [26:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [53:0] mul_p;
	logic [18:0]        max_rate_p1;

	assign cw            = ucode(pc_q);
	assign s_axis_tready = !busy_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign emit_go       = busy_q && (cw.op == OP_EMIT) && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Time checks, integration, settle bands and command scaling
	always_comb begin
		elapsed    = now_q - start_q;
		timed_out  = elapsed >= lat_timeout_q;
		dt_raw     = now_q - last_q;
		dt_next    = (dt_raw == 32'd0 || dt_raw > DT_MAX) ? DT_FALLBACK : dt_raw[8:0];
		start_ok   = (cfg_target_q != 21'sd0) && (cfg_timeout_q != 32'd0);
		sum49      = {turned_q[47], turned_q} + $signed(prod_q[48:0]);
		if (sum49[48] != sum49[47]) begin
			turned_sat = sum49[48] ? TURN_MIN : TURN_MAX;
		end else begin
			turned_sat = sum49[47:0];
		end
		err_next   = $signed(prod_q[48:0]) - $signed({turned_q[47], turned_q});
		err_neg    = -err_q;
		tol_pos    = $signed({24'd0, prod_q[24:0]});
		rate_abs   = rate_q[19] ? 20'(-rate_q) : 20'(rate_q);
		settled    = (err_q <= tol_pos) && (err_q >= -tol_pos)
			&& (rate_abs <= {4'd0, cfg_rate_lim_q});
		settle_hit = (now_q - sst_q) >= {16'd0, cfg_settle_q};
		if (err_q > ERR_LIM || err_q < -ERR_LIM) begin
			emag_next = EMAG_LIM;
		end else begin
			emag_next = err_q[48] ? err_neg[37:0] : err_q[37:0];
		end
		quo_pre     = pm_q[54:11];
		max_rate_p1 = {1'b0, cfg_max_rate_q} + 19'd1;
		mag         = big_q ? cfg_max_rate_q : prod_q[49:32];
		mag19       = {1'b0, mag};
		cmd_next    = esign_q ? $signed(-mag19) : $signed(mag19);
		end_now     = 1'b0;
		unique case (cw.op)
			OP_DECODE: end_now = !(req_q == REQ_UPDATE && running_q && !timed_out);
			OP_SETTLE: end_now = settled && settling_q && settle_hit;
			default:   end_now = 1'b0;
		endcase
	end

	// Select the shared multiplier's operands
	always_comb begin
		mul_a = 27'sd0;
		mul_b = 27'sd0;
		unique case (cw.op)
			OP_MUL_RATE: begin
				mul_a = 27'(rate_q);
				mul_b = $signed({18'd0, dt_q});
			end
			OP_ACCUM: begin
				mul_a = 27'(lat_target_q);
				mul_b = K_MILLI;
			end
			OP_ERROR: begin
				mul_a = $signed({12'd0, cfg_tol_q});
				mul_b = K_MILLI;
			end
			OP_PROD_LO: begin
				mul_a = $signed({11'd0, cfg_gain_q});
				mul_b = $signed({8'd0, emag_q[18:0]});
			end
			OP_PROD_HI: begin
				mul_a = $signed({11'd0, cfg_gain_q});
				mul_b = $signed({8'd0, emag_q[37:19]});
			end
			OP_ROUND: begin
				mul_a = $signed({8'd0, max_rate_p1});
				mul_b = K_DIV;
			end
			OP_SCALE: begin
				mul_a = $signed({2'd0, quo_pre[24:0]});
				mul_b = K_RECIP;
			end
			default: begin
				mul_a = 27'sd0;
				mul_b = 27'sd0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_target_q   <= 21'sd0;
			cfg_timeout_q  <= 32'd0;
			cfg_gain_q     <= GAIN_RST;
			cfg_max_rate_q <= MAX_RATE_RST;
			cfg_tol_q      <= TOL_RST;
			cfg_rate_lim_q <= RATE_LIM_RST;
			cfg_settle_q   <= SETTLE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TARGET:   cfg_target_q   <= $signed(cfg_data[20:0]);
				REG_TIMEOUT:  cfg_timeout_q  <= cfg_data;
				REG_GAIN:     cfg_gain_q     <= cfg_data[15:0];
				REG_MAX_RATE: cfg_max_rate_q <= cfg_data[17:0];
				REG_TOL:      cfg_tol_q      <= cfg_data[14:0];
				REG_RATE_LIM: cfg_rate_lim_q <= cfg_data[15:0];
				REG_SETTLE:   cfg_settle_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Step the program and update the turn state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pc_q          <= STEP_DECODE;
			running_q     <= 1'b0;
			settling_q    <= 1'b0;
			turned_q      <= 48'sd0;
			last_q        <= 32'd0;
			start_q       <= 32'd0;
			sst_q         <= 32'd0;
			finish_q      <= END_NONE;
			lat_target_q  <= 21'sd0;
			lat_timeout_q <= 32'd0;
			cmd_q         <= 19'sd0;
			valid_q       <= 1'b0;
			accepted_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// drop the output word once taken
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				busy_q     <= 1'b1;
				pc_q       <= STEP_DECODE;
				cmd_q      <= 19'sd0;
				valid_q    <= 1'b0;
				accepted_q <= 1'b0;
			end else if (busy_q) begin
				// advance, jump on an ended item, hold at emit until the output frees
				if (cw.op == OP_EMIT) begin
					if (out_free) begin
						busy_q <= 1'b0;
						pc_q   <= STEP_DECODE;
					end
				end else if (cw.jmp == JMP_IF_END && end_now) begin
					pc_q <= cw.target;
				end else begin
					pc_q <= pc_q + 4'd1;
				end
				unique case (cw.op)
					OP_DECODE: begin
						case (req_q)
							REQ_START: begin
								if (start_ok) begin
									running_q     <= 1'b1;
									settling_q    <= 1'b0;
									turned_q      <= 48'sd0;
									last_q        <= now_q;
									start_q       <= now_q;
									sst_q         <= 32'd0;
									finish_q      <= END_NONE;
									lat_target_q  <= cfg_target_q;
									lat_timeout_q <= cfg_timeout_q;
									accepted_q    <= 1'b1;
								end
							end
							REQ_CANCEL: begin
								running_q  <= 1'b0;
								settling_q <= 1'b0;
								finish_q   <= reason_q;
							end
							REQ_UPDATE: begin
								if (running_q && timed_out) begin
									running_q  <= 1'b0;
									settling_q <= 1'b0;
									finish_q   <= END_TIMEOUT;
								end
							end
							default: ;
						endcase
					end
					OP_MUL_RATE: last_q <= now_q;
					OP_ACCUM:    turned_q <= turned_sat;
					OP_SETTLE: begin
						if (settled) begin
							if (!settling_q) begin
								settling_q <= 1'b1;
								sst_q      <= now_q;
							end else if (settle_hit) begin
								running_q  <= 1'b0;
								settling_q <= 1'b0;
								finish_q   <= END_COMPLETED;
							end
						end else begin
							settling_q <= 1'b0;
						end
					end
					OP_COMMAND: begin
						cmd_q   <= cmd_next;
						valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q    <= s_axis_tuser;
			now_q    <= s_axis_tdata[31:0];
			rate_q   <= $signed(s_axis_tdata[51:32]);
			reason_q <= s_axis_tdata[53:52];
		end
		if (busy_q) begin
			unique case (cw.op)
				OP_DECODE:   dt_q <= dt_next;
				OP_MUL_RATE: prod_q <= mul_p;
				OP_ACCUM:    prod_q <= mul_p;
				OP_ERROR: begin
					err_q  <= err_next;
					prod_q <= mul_p;
				end
				OP_SETTLE: begin
					emag_q  <= emag_next;
					esign_q <= err_q[48];
				end
				OP_PROD_LO:  prod_q <= mul_p;
				OP_PROD_HI: begin
					pm_q   <= {1'b0, prod_q} + K_HALF;
					prod_q <= mul_p;
				end
				OP_ROUND: begin
					pm_q   <= pm_q + {prod_q[35:0], 19'd0};
					prod_q <= mul_p;
				end
				OP_SCALE: begin
					big_q  <= quo_pre >= {18'd0, prod_q[25:0]};
					prod_q <= mul_p;
				end
				OP_COMMAND: ;
				OP_EMIT: begin
					if (out_free) begin
						out_data_q <= {finish_q, running_q, accepted_q, valid_q, cmd_q};
					end
				end
				default: ;
			endcase
		end
	end

	`RYT_ASSERT_IMP(a_idle_at_entry, !busy_q, pc_q == STEP_DECODE)
	`RYT_ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, busy_q && pc_q == STEP_DECODE)
	`RYT_ASSERT_IMP(a_cmd_needs_turn, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[21] && m_axis_tdata[23:22] == END_NONE)
	`RYT_ASSERT_IMP(a_start_no_cmd, m_axis_tvalid && m_axis_tdata[20], !m_axis_tdata[19] && m_axis_tdata[21])

endmodule

FILE: test/relative_yaw_turn_controller_test.sv
`timescale 1ns / 100ps

module relative_yaw_turn_controller_test;
	import ryt_pkg::*;

	// Request kind that the block ignores
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam int     CYCLE_LIMIT      = 400000;
	localparam int     RANDOM_REQS      = 950;
	localparam longint STEP_FALLBACK_MS = 20;
	localparam longint STEP_LIMIT_MS    = 500;
	localparam longint TURNED_TOP       = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ERR_TOP          = 64'sd137438953472;
	localparam longint CMD_HALF         = 128000;
	localparam longint CMD_SCALE        = 256000;
	localparam longint MILLI            = 1000;

	typedef struct {
		logic [1:0]         kind;
		logic [31:0]        now;
		logic signed [19:0] rate;
		logic [1:0]         reason;
		int unsigned        gap;
	} turn_req_t;

	typedef struct packed {
		logic signed [18:0] turn_rate;
		logic               command_valid;
		logic               start_accepted;
		logic               turn_active;
		logic [1:0]         end_code;
	} turn_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;  // now_ms[31:0], yaw_rate[51:32], cancel_reason[53:52]
	logic [1:0]  s_axis_tuser;  // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // turn_rate[18:0], command_valid[19],
	                            // start_accepted[20], turn_active[21], end_code[23:22]
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_data;

	// Register copies as the block should hold them
	logic signed [20:0] ctl_target   = '0;
	logic [31:0]        ctl_timeout  = '0;
	logic [15:0]        ctl_gain     = GAIN_RST;
	logic [17:0]        ctl_max_rate = MAX_RATE_RST;
	logic [14:0]        ctl_tol      = TOL_RST;
	logic [15:0]        ctl_rate_lim = RATE_LIM_RST;
	logic [15:0]        ctl_settle   = SETTLE_RST;

	// Turn state as the block should hold it
	bit          turn_on       = 1'b0;
	bit          settle_armed  = 1'b0;
	longint      turned        = 0;
	logic [31:0] last_ms       = '0;
	logic [31:0] turn_begin_ms = '0;
	logic [31:0] settle_ms     = '0;
	logic [1:0]  finish_code   = END_NONE;
	longint      held_target   = 0;
	logic [31:0] held_timeout  = '0;

	turn_req_t  pending_reqs[$];
	turn_word_t expected_words[$];
	turn_req_t  next_req, live_req;
	bit         next_ready = 1'b0;
	int         gap_left = 0;
	bit         word_taken = 1'b0;
	bit         word_out = 1'b0;
	int         stall_left = 0;
	bit         feed_calm = 1'b0;
	bit         sink_calm = 1'b0;
	int         queued_reqs = 0;
	int         accepted_reqs = 0;
	int         planned_reqs = 0;
	int         failures = 0;
	int         cycle_count = 0;

	// Open-loop plant guess used to steer turns towards settling
	logic [31:0] gen_ms = '0;
	longint      gen_turned = 0;
	longint      gen_goal = 0;

	relative_yaw_turn_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Work out the result word that one request should give, advancing the turn state
	task automatic predict_turn(input turn_req_t r, output turn_word_t w);
		logic [31:0] span;
		longint      step, err, err_mag, rate_val, rate_mag, prod, mag;
		bit          finished;
		w = '0;
		finished = 1'b0;
		case (r.kind)
			REQ_START: begin
				if (ctl_target != 0 && ctl_timeout != 0) begin
					turn_on = 1'b1;
					settle_armed = 1'b0;
					turned = 0;
					last_ms = r.now;
					turn_begin_ms = r.now;
					settle_ms = '0;
					finish_code = END_NONE;
					held_target = ctl_target;
					held_timeout = ctl_timeout;
					w.start_accepted = 1'b1;
				end
			end
			REQ_CANCEL: begin
				turn_on = 1'b0;
				settle_armed = 1'b0;
				finish_code = r.reason;
			end
			REQ_UPDATE: begin
				if (turn_on) begin
					span = r.now - turn_begin_ms;
					if (span >= held_timeout) begin
						turn_on = 1'b0;
						settle_armed = 1'b0;
						finish_code = END_TIMEOUT;
					end else begin
						// time step with fallback for a stale or repeated stamp
						span = r.now - last_ms;
						if (span == 0 || span > STEP_LIMIT_MS)
							step = STEP_FALLBACK_MS;
						else
							step = span;
						last_ms = r.now;
						rate_val = r.rate;
						turned += rate_val * step;
						if (turned > TURNED_TOP)
							turned = TURNED_TOP;
						else if (turned < -TURNED_TOP - 1)
							turned = -TURNED_TOP - 1;
						err = held_target * MILLI - turned;
						err_mag = err < 0 ? -err : err;
						rate_mag = rate_val < 0 ? -rate_val : rate_val;
						// settle window: arm on first settled update, finish once held long enough
						if (err_mag <= longint'(ctl_tol) * MILLI &&
								rate_mag <= longint'(ctl_rate_lim)) begin
							if (!settle_armed) begin
								settle_armed = 1'b1;
								settle_ms = r.now;
							end else begin
								span = r.now - settle_ms;
								if (span >= ctl_settle) begin
									turn_on = 1'b0;
									settle_armed = 1'b0;
									finish_code = END_COMPLETED;
									finished = 1'b1;
								end
							end
						end else begin
							settle_armed = 1'b0;
						end
						// proportional command, rounded half away from zero, then clamped
						if (!finished) begin
							if (err > ERR_TOP)
								err = ERR_TOP;
							else if (err < -ERR_TOP)
								err = -ERR_TOP;
							prod = longint'(ctl_gain) * err;
							mag = prod < 0 ? -prod : prod;
							mag = (mag + CMD_HALF) / CMD_SCALE;
							if (mag > longint'(ctl_max_rate))
								mag = ctl_max_rate;
							w.turn_rate = 19'(prod < 0 ? -mag : mag);
							w.command_valid = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		w.turn_active = turn_on;
		w.end_code = finish_code;
	endtask

	// Accept input words, predict them, and check output words
	always @(posedge clk) begin : watch
		turn_word_t fresh, want;
		if (s_axis_tvalid && s_axis_tready) begin
			word_taken = 1'b1;
			predict_turn(live_req, fresh);
			expected_words.push_back(fresh);
			accepted_reqs++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			word_out = 1'b1;
			if (expected_words.size() == 0) begin
				$error("result word %h with no request pending", m_axis_tdata);
				failures++;
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tdata[18:0] !== want.turn_rate) begin
					$error("turn_rate: expected %0d, got %0d", want.turn_rate,
						$signed(m_axis_tdata[18:0]));
					failures++;
				end
				if (m_axis_tdata[19] !== want.command_valid) begin
					$error("command_valid: expected %0d, got %0d", want.command_valid,
						m_axis_tdata[19]);
					failures++;
				end
				if (m_axis_tdata[20] !== want.start_accepted) begin
					$error("start_accepted: expected %0d, got %0d", want.start_accepted,
						m_axis_tdata[20]);
					failures++;
				end
				if (m_axis_tdata[21] !== want.turn_active) begin
					$error("turn_active: expected %0d, got %0d", want.turn_active,
						m_axis_tdata[21]);
					failures++;
				end
				if (m_axis_tdata[23:22] !== want.end_code) begin
					$error("end_code: expected %0d, got %0d", want.end_code,
						m_axis_tdata[23:22]);
					failures++;
				end
			end
		end
	end

	// Feed request words: hold until taken, then wait out the next gap
	always @(negedge clk) begin
		if (!s_axis_tvalid || word_taken) begin
			word_taken = 1'b0;
			if (!next_ready && pending_reqs.size() > 0) begin
				next_req = pending_reqs.pop_front();
				next_ready = 1'b1;
				gap_left = next_req.gap;
			end
			if (next_ready && gap_left == 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {2'b00, next_req.reason, next_req.rate, next_req.now};
				s_axis_tuser <= next_req.kind;
				live_req = next_req;
				next_ready = 1'b0;
			end else begin
				s_axis_tvalid <= 1'b0;
				if (next_ready)
					gap_left--;
			end
		end
	end

	// Stall the result side for a drawn number of cycles once a word is waiting
	always @(negedge clk) begin
		if (word_out) begin
			word_out = 1'b0;
			if ($urandom_range(0, 40) == 0)
				sink_calm = !sink_calm;
			stall_left = sink_calm ? 0 : $urandom_range(0, 4);
		end
		if (stall_left > 0 && m_axis_tvalid) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic add_req(input logic [1:0] kind, input logic [31:0] now,
			input logic signed [19:0] rate, input logic [1:0] reason);
		turn_req_t r;
		if ($urandom_range(0, 29) == 0)
			feed_calm = !feed_calm;
		r.kind = kind;
		r.now = now;
		r.rate = rate;
		r.reason = reason;
		r.gap = feed_calm ? 0 : $urandom_range(0, 4);
		pending_reqs.push_back(r);
		queued_reqs++;
	endtask

	// Wait until every word is through, then let the block settle
	task automatic drain_block();
		do @(negedge clk);
		while (accepted_reqs != queued_reqs || expected_words.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_TARGET:   ctl_target = val[20:0];
			REG_TIMEOUT:  ctl_timeout = val;
			REG_GAIN:     ctl_gain = val[15:0];
			REG_MAX_RATE: ctl_max_rate = val[17:0];
			REG_TOL:      ctl_tol = val[14:0];
			REG_RATE_LIM: ctl_rate_lim = val[15:0];
			REG_SETTLE:   ctl_settle = val[15:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Draw a register setting: mostly working values, sometimes an extreme
	function automatic logic [31:0] pick_setting(input logic [2:0] idx);
		int unsigned        roll;
		logic signed [20:0] t;
		logic [31:0]        val;
		roll = $urandom_range(0, 15);
		val = '0;
		case (idx)
			REG_TARGET: begin
				case (roll)
					0: t = 21'h100000;
					1: t = 21'h0FFFFF;
					2: t = '0;
					default: begin
						t = 21'($urandom_range(64, 46080));
						if ($urandom_range(0, 1))
							t = -t;
					end
				endcase
				val = {{11{t[20]}}, t};
			end
			REG_TIMEOUT: begin
				case (roll)
					0: val = '0;
					1: val = 32'hFFFF_FFFF;
					2: val = 32'd1;
					3, 4, 5: val = $urandom_range(50, 600);
					default: val = $urandom_range(1000, 20000);
				endcase
			end
			REG_GAIN:     val = roll == 0 ? 0 : roll == 1 ? 65535 : $urandom_range(500, 8000);
			REG_MAX_RATE: val = roll == 0 ? 0 : roll == 1 ? 262143 : $urandom_range(20000, 150000);
			REG_TOL:      val = roll == 0 ? 0 : roll == 1 ? 32767 : $urandom_range(64, 3000);
			REG_RATE_LIM: val = roll == 0 ? 0 : roll == 1 ? 65535 : $urandom_range(100, 3000);
			REG_SETTLE:   val = roll == 0 ? 0 : roll == 1 ? 65535 : $urandom_range(20, 200);
			default: begin
			end
		endcase
		return val;
	endfunction

	// Plan one phase: mostly whole turns steered towards the target, with noise between
	task automatic plan_phase(input int quota);
		int          made, steps;
		int unsigned sel;
		longint      step, eff, remain, rate_l;
		logic [1:0]  kind;
		logic [31:0] now;
		made = 0;
		while (made < quota) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				gen_ms += $urandom_range(1, 3000);
				add_req(REQ_START, gen_ms, 20'($urandom), 2'($urandom));
				gen_turned = 0;
				gen_goal = longint'(ctl_target) * MILLI;
				steps = $urandom_range(4, 40);
				repeat (steps) begin
					case ($urandom_range(0, 15))
						0: step = 0;
						1: step = $urandom_range(501, 100000);
						2: step = STEP_LIMIT_MS;
						3: step = STEP_LIMIT_MS + 1;
						default: step = $urandom_range(5, 40);
					endcase
					gen_ms += 32'(step);
					eff = (step == 0 || step > STEP_LIMIT_MS) ? STEP_FALLBACK_MS : step;
					remain = gen_goal - gen_turned;
					rate_l = remain / (2 * eff);
					if ($urandom_range(0, 7) == 0)
						rate_l += int'($urandom_range(0, 600)) - 300;
					if (rate_l > 524287)
						rate_l = 524287;
					else if (rate_l < -524288)
						rate_l = -524288;
					gen_turned += rate_l * eff;
					add_req(REQ_UPDATE, gen_ms, 20'(rate_l), 2'($urandom));
					if ($urandom_range(0, 59) == 0) begin
						add_req(REQ_CANCEL, gen_ms, 20'($urandom), 2'($urandom));
						made++;
					end
				end
				made += steps + 1;
			end else if (sel < 92) begin
				kind = 2'($urandom);
				now = $urandom_range(0, 3) == 0 ? $urandom : gen_ms + $urandom_range(0, 600);
				add_req(kind, now, 20'($urandom), 2'($urandom));
				if (kind != REQ_SPARE)
					made++;
			end else begin
				add_req(REQ_CANCEL, gen_ms, 20'($urandom), 2'($urandom));
				made++;
			end
		end
		planned_reqs += made;
	endtask

	initial begin
		logic [2:0] reg_list[7];
		bit         first_phase;
		reg_list = '{REG_TARGET, REG_TIMEOUT, REG_GAIN, REG_MAX_RATE, REG_TOL,
			REG_RATE_LIM, REG_SETTLE};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_UPDATE;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_TARGET;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Idle block at defaults: refused start, idle update, cancel, ignored kind
		add_req(REQ_UPDATE, 32'd0, 20'sd0, 2'd0);
		add_req(REQ_START, 32'd100, 20'sd0, 2'd0);
		add_req(REQ_CANCEL, 32'd200, 20'sd0, 2'd3);
		add_req(REQ_SPARE, 32'hFFFF_FFFF, -20'sd524288, 2'd1);
		drain_block();

		// Most negative target: saturated command, wrapping clock, step edge cases
		write_reg(REG_TARGET, 32'hFFF0_0000);
		write_reg(REG_TIMEOUT, 32'd5000);
		add_req(REQ_START, 32'hFFFF_FFF0, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'hFFFF_FFF0, 20'sd524287, 2'd0);
		add_req(REQ_UPDATE, 32'h0000_01E4, -20'sd524288, 2'd0);
		add_req(REQ_UPDATE, 32'h0000_03D9, 20'sd0, 2'd0);
		add_req(REQ_SPARE, 32'h0000_03E0, 20'sd1, 2'd2);
		// restart while running, cancel, idle update
		add_req(REQ_START, 32'd2000, 20'sd0, 2'd0);
		add_req(REQ_CANCEL, 32'd2010, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd2020, 20'sd100, 2'd0);
		// timeout one millisecond after the last live update
		add_req(REQ_START, 32'd3000, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd7999, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd8000, 20'sd0, 2'd0);
		add_req(REQ_CANCEL, 32'd8010, 20'sd0, 2'd1);
		add_req(REQ_CANCEL, 32'd8020, 20'sd0, 2'd2);
		drain_block();

		// Widest bands and zero hold time: completion on the second settled update
		write_reg(REG_TARGET, 32'd256);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_GAIN, 32'd65535);
		write_reg(REG_MAX_RATE, 32'd262143);
		write_reg(REG_TOL, 32'd32767);
		write_reg(REG_RATE_LIM, 32'd65535);
		write_reg(REG_SETTLE, 32'd0);
		add_req(REQ_START, 32'd0, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd20, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd40, 20'sd0, 2'd0);
		add_req(REQ_UPDATE, 32'd60, 20'sd0, 2'd0);

		// Random phases, registers rewritten only once the block is idle
		first_phase = 1'b1;
		gen_ms = $urandom;
		while (planned_reqs < RANDOM_REQS) begin
			drain_block();
			foreach (reg_list[i])
				if (first_phase || $urandom_range(0, 1))
					write_reg(reg_list[i], pick_setting(reg_list[i]));
			first_phase = 1'b0;
			plan_phase($urandom_range(30, 90));
		end
		drain_block();

		if (failures == 0 && expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
